@@ sv/gaussian_overlap_screen_assert.svh @@
`ifndef GAUSSIAN_OVERLAP_SCREEN_ASSERT_SVH
`define GAUSSIAN_OVERLAP_SCREEN_ASSERT_SVH

// Implication checked in the same cycle, sampled on the rising clock edge.
`define GOS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the following cycle.
`define GOS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/gos_pkg.sv @@
package gos_pkg;

    localparam logic [63:0] LN2_Q64  = 64'hB17217F7D1CF79AB;
    localparam logic [63:0] ONE_Q62  = 64'h4000000000000000;
    localparam logic [63:0] ONE_Q48  = 64'h0001000000000000;
    localparam int          EXP_TERMS = 24;

    localparam logic [1:0] REG_PREFACTOR = 2'd0;
    localparam logic [1:0] REG_DECAY     = 2'd1;
    localparam logic [1:0] REG_TOTAL_L   = 2'd2;
    localparam logic [1:0] REG_CUTOFF    = 2'd3;

    // Everything one pair carries down the pipeline.
    typedef struct packed {
        logic [2:0][31:0] d;
        logic [2:0][63:0] sq;
        logic [63:0]      r2;
        logic             xz;
        logic [69:0]      xr;
        logic [6:0]       k;
        logic [61:0]      f;
        logic [63:0]      t;
        logic [63:0]      s;
        logic [7:0][63:0] pp;
        logic [127:0]     pa;
        logic [127:0]     pb;
        logic [48:0]      e;
        logic [65:0]      rem;
        logic [63:0]      root;
        logic [127:0]     p;
        logic             sig;
    } pay_t;

endpackage

@@ sv/gaussian_overlap_screen.sv @@
// Throughput: one pair per cycle; every stage advances together whenever the
// output register is empty or its beat is taken, so a stall holds the whole pipeline.
// Stages: 7 for exp range reduction, 5 per Taylor term, 64 for the square root and
// 2 per power step; wide products are 32x32 partial products summed one stage later.
// Reset (rst_n low, asynchronous) empties the pipeline and clears the configuration registers to 0.
module gaussian_overlap_screen #(
    parameter int MAX_L = 12
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // bra_x, bra_y, bra_z, ket_x, ket_y, ket_z (32 bits each, from bit 0 up)
    input  logic [191:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // significant in bit 0, bits 7:1 zero
    output logic [7:0]   m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);

    localparam int ST_SQ   = 1;
    localparam int ST_SUM  = 2;
    localparam int ST_XP   = 3;
    localparam int ST_X    = 4;
    localparam int ST_K0   = 5;
    localparam int ST_TI   = ST_K0 + 7;
    localparam int ST_T0   = ST_TI + 1;
    localparam int ST_E    = ST_T0 + 5 * gos_pkg::EXP_TERMS;
    localparam int ST_R0   = ST_E + 1;
    localparam int ST_P0   = ST_R0 + 64;
    localparam int ST_FL   = ST_P0 + 2 * MAX_L;
    localparam int ST_M1P  = ST_FL + 1;
    localparam int ST_M1   = ST_FL + 2;
    localparam int ST_M2P  = ST_FL + 3;
    localparam int ST_M2   = ST_FL + 4;
    localparam int LAST    = ST_FL + 5;

    logic [47:0] prefactor_reg;
    logic [47:0] decay_reg;
    logic [3:0]  total_l_reg;
    logic [63:0] cutoff_reg;
    logic [4:0]  lcl;
    logic        cfg_wr;
    logic        en;

    gos_pkg::pay_t stg_next [0:LAST];
    gos_pkg::pay_t pipe_reg [0:LAST];
    logic [LAST:0] vld_reg;

    // All 32x32 partial products of a 128-bit by 64-bit product; entry 2*i+j
    // holds limb i of a times limb j of b.
    function automatic logic [7:0][63:0] pp_mul(input logic [127:0] a, input logic [63:0] b);
        logic [7:0][63:0] pp;
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 2; j++)
                pp[2*i+j] = 64'(a[32*i +: 32]) * 64'(b[32*j +: 32]);
        return pp;
    endfunction

    // Partial products that do not overlap are concatenated, leaving four addends.
    function automatic logic [191:0] pp_sum(input logic [7:0][63:0] pp);
        logic [127:0] r00;
        logic [127:0] r10;
        logic [127:0] r01;
        logic [127:0] r11;
        r00 = {pp[4], pp[0]};
        r10 = {pp[6], pp[2]};
        r01 = {pp[5], pp[1]};
        r11 = {pp[7], pp[3]};
        return (192'(r00) + (192'(r11) << 64)) + ((192'(r10) + 192'(r01)) << 32);
    endfunction

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefactor_reg <= '0;
            decay_reg     <= '0;
            total_l_reg   <= '0;
            cutoff_reg    <= '0;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:3])
                gos_pkg::REG_PREFACTOR: prefactor_reg <= pwdata[47:0];
                gos_pkg::REG_DECAY:     decay_reg     <= pwdata[47:0];
                gos_pkg::REG_TOTAL_L:   total_l_reg   <= pwdata[3:0];
                gos_pkg::REG_CUTOFF:    cutoff_reg    <= pwdata;
                default:                cutoff_reg    <= cutoff_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:3])
            gos_pkg::REG_PREFACTOR: prdata = {16'd0, prefactor_reg};
            gos_pkg::REG_DECAY:     prdata = {16'd0, decay_reg};
            gos_pkg::REG_TOTAL_L:   prdata = {60'd0, total_l_reg};
            gos_pkg::REG_CUTOFF:    prdata = cutoff_reg;
            default:                prdata = '0;
        endcase
    end

    assign lcl = (5'(total_l_reg) > 5'(MAX_L)) ? 5'(MAX_L) : 5'(total_l_reg);

    // Handshake: the whole pipeline moves when the output register can move.
    assign en            = !vld_reg[LAST] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[LAST];
    assign m_axis_tdata  = {7'd0, pipe_reg[LAST].sig};

    // First stage: absolute coordinate differences.
    always_comb
    begin
        logic signed [32:0] df;
        stg_next[0] = '0;
        for (int i = 0; i < 3; i++)
        begin
            df = {s_axis_tdata[32*i+31], s_axis_tdata[32*i +: 32]}
               - {s_axis_tdata[32*(i+3)+31], s_axis_tdata[32*(i+3) +: 32]};
            stg_next[0].d[i] = df[32] ? 32'(-df) : df[31:0];
        end
    end

    for (genvar g = 1; g <= LAST; g++)
    begin : g_stg
        if (g == ST_SQ)
        begin : g_sq
            always_comb
            begin
                stg_next[g] = pipe_reg[g-1];
                for (int i = 0; i < 3; i++)
                    stg_next[g].sq[i] = {32'd0, pipe_reg[g-1].d[i]}
                                      * {32'd0, pipe_reg[g-1].d[i]};
            end
        end
        else if (g == ST_SUM)
        begin : g_sum
            always_comb
            begin
                logic [65:0] sm;
                stg_next[g] = pipe_reg[g-1];
                sm = 66'(pipe_reg[g-1].sq[0]) + 66'(pipe_reg[g-1].sq[1])
                   + 66'(pipe_reg[g-1].sq[2]);
                stg_next[g].r2 = (|sm[65:64]) ? '1 : sm[63:0];
            end
        end
        else if (g == ST_XP)
        begin : g_xp
            always_comb
            begin
                stg_next[g] = pipe_reg[g-1];
                stg_next[g].pp = pp_mul(128'(pipe_reg[g-1].r2), 64'(decay_reg));
            end
        end
        else if (g == ST_X)
        begin : g_x
            always_comb
            begin
                logic [191:0] xp;
                stg_next[g] = pipe_reg[g-1];
                xp = pp_sum(pipe_reg[g-1].pp);
                // An integer part of 64 or more underflows exp to zero.
                stg_next[g].xz = |xp[191:70];
                stg_next[g].xr = xp[69:0];
                stg_next[g].k  = '0;
            end
        end
        else if (g >= ST_K0 && g < ST_TI)
        begin : g_k
            localparam int KJ = 6 - (g - ST_K0);
            always_comb
            begin
                logic [69:0] sub;
                stg_next[g] = pipe_reg[g-1];
                sub = 70'(gos_pkg::LN2_Q64) << KJ;
                if (pipe_reg[g-1].xr >= sub)
                begin
                    stg_next[g].xr    = pipe_reg[g-1].xr - sub;
                    stg_next[g].k[KJ] = 1'b1;
                end
            end
        end
        else if (g == ST_TI)
        begin : g_ti
            always_comb
            begin
                stg_next[g] = pipe_reg[g-1];
                stg_next[g].xz = pipe_reg[g-1].xz | pipe_reg[g-1].k[6];
                stg_next[g].f  = pipe_reg[g-1].xr[63:2];
                stg_next[g].t  = gos_pkg::ONE_Q62;
                stg_next[g].s  = gos_pkg::ONE_Q62;
            end
        end
        else if (g >= ST_T0 && g < ST_E)
        begin : g_tay
            localparam int TN = (g - ST_T0) / 5 + 1;
            localparam int PH = (g - ST_T0) % 5;
            localparam logic [64:0] RECIP = 65'h1_0000_0000_0000_0000 / 65'(TN);
            always_comb
            begin
                logic [63:0]  v;
                logic [191:0] pr;
                logic [63:0]  q0;
                logic [63:0]  rr;
                logic [63:0]  tq;
                stg_next[g] = pipe_reg[g-1];
                v  = pipe_reg[g-1].pb[127:64];
                q0 = pipe_reg[g-1].pb[63:0];
                pr = '0;
                rr = '0;
                tq = '0;
                case (PH)
                    0:
                    begin
                        stg_next[g].pp = pp_mul(128'(pipe_reg[g-1].t), 64'(pipe_reg[g-1].f));
                    end
                    1:
                    begin
                        pr = pp_sum(pipe_reg[g-1].pp);
                        stg_next[g].pb[127:64] = pr[125:62];
                    end
                    2:
                    begin
                        // Quotient by the term index via its reciprocal; low by one at most.
                        stg_next[g].pp = pp_mul(128'(v), RECIP[63:0]);
                    end
                    3:
                    begin
                        pr = pp_sum(pipe_reg[g-1].pp);
                        stg_next[g].pb[63:0] = (TN == 1) ? v : pr[127:64];
                    end
                    default:
                    begin
                        rr = v - q0 * 64'(TN);
                        tq = (rr >= 64'(TN)) ? q0 + 64'd1 : q0;
                        stg_next[g].t = tq;
                        stg_next[g].s = (TN % 2 == 1) ? pipe_reg[g-1].s - tq
                                                      : pipe_reg[g-1].s + tq;
                    end
                endcase
            end
        end
        else if (g == ST_E)
        begin : g_e
            always_comb
            begin
                logic [63:0] es;
                stg_next[g] = pipe_reg[g-1];
                es = (pipe_reg[g-1].s >> 14) >> pipe_reg[g-1].k[5:0];
                stg_next[g].e    = pipe_reg[g-1].xz ? '0 : es[48:0];
                stg_next[g].rem  = '0;
                stg_next[g].root = '0;
                stg_next[g].p    = 128'(gos_pkg::ONE_Q48);
            end
        end
        else if (g >= ST_R0 && g < ST_P0)
        begin : g_sqrt
            localparam int SB = 63 - (g - ST_R0);
            localparam int PB = (SB >= 32) ? 2 * SB - 64 : 0;
            localparam bit PV = (SB >= 32);
            always_comb
            begin
                logic [1:0]  pair;
                logic [67:0] sh;
                logic [65:0] trial;
                stg_next[g] = pipe_reg[g-1];
                // The radicand is r2 followed by 64 zero bits.
                pair  = PV ? pipe_reg[g-1].r2[PB +: 2] : 2'b00;
                sh    = {pipe_reg[g-1].rem, pair};
                trial = {pipe_reg[g-1].root, 2'b01};
                if (sh >= 68'(trial))
                begin
                    stg_next[g].rem  = 66'(sh - 68'(trial));
                    stg_next[g].root = {pipe_reg[g-1].root[62:0], 1'b1};
                end
                else
                begin
                    stg_next[g].rem  = sh[65:0];
                    stg_next[g].root = {pipe_reg[g-1].root[62:0], 1'b0};
                end
            end
        end
        else if (g >= ST_P0 && g < ST_FL)
        begin : g_pow
            localparam int PJ  = (g - ST_P0) / 2;
            localparam int PPH = (g - ST_P0) % 2;
            always_comb
            begin
                logic [191:0] w;
                stg_next[g] = pipe_reg[g-1];
                w = pp_sum(pipe_reg[g-1].pp);
                if (PPH == 0)
                begin
                    stg_next[g].pp = pp_mul(pipe_reg[g-1].p, pipe_reg[g-1].root);
                end
                else if (lcl > 5'(PJ))
                begin
                    stg_next[g].p = (|w[191:176]) ? '1 : w[175:48];
                end
            end
        end
        else if (g == ST_FL)
        begin : g_fl
            always_comb
            begin
                stg_next[g] = pipe_reg[g-1];
                if (pipe_reg[g-1].p[127:48] == '0)
                    stg_next[g].p = 128'(gos_pkg::ONE_Q48);
            end
        end
        else if (g == ST_M1P)
        begin : g_m1p
            always_comb
            begin
                stg_next[g] = pipe_reg[g-1];
                stg_next[g].pp = pp_mul(pipe_reg[g-1].p, 64'(pipe_reg[g-1].e));
            end
        end
        else if (g == ST_M1)
        begin : g_m1
            always_comb
            begin
                logic [191:0] pe;
                stg_next[g] = pipe_reg[g-1];
                pe = pp_sum(pipe_reg[g-1].pp);
                stg_next[g].pa = pe[175:48];
            end
        end
        else if (g == ST_M2P)
        begin : g_m2p
            always_comb
            begin
                stg_next[g] = pipe_reg[g-1];
                stg_next[g].pp = pp_mul(pipe_reg[g-1].pa, 64'(prefactor_reg));
            end
        end
        else if (g == ST_M2)
        begin : g_m2
            always_comb
            begin
                logic [191:0] w2;
                stg_next[g] = pipe_reg[g-1];
                w2 = pp_sum(pipe_reg[g-1].pp);
                stg_next[g].sig = |w2[191:88];
                stg_next[g].t   = w2[87:24];
            end
        end
        else
        begin : g_cmp
            always_comb
            begin
                stg_next[g] = pipe_reg[g-1];
                stg_next[g].sig = pipe_reg[g-1].sig | (pipe_reg[g-1].t >= cutoff_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAST-1:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i <= LAST; i++)
                pipe_reg[i] <= stg_next[i];
        end
    end

    // Checks on intermediate results.
    logic [65:0] root_x2;
    assign root_x2 = {1'b0, pipe_reg[ST_P0-1].root, 1'b0};

    `include "gaussian_overlap_screen_assert.svh"

    `GOS_ASSERT_NOW(a_sqrt_floor, vld_reg[ST_P0-1], pipe_reg[ST_P0-1].rem <= root_x2, "square root remainder above twice the root")
    `GOS_ASSERT_NOW(a_reduced, vld_reg[ST_TI-1] && !pipe_reg[ST_TI-1].xz, pipe_reg[ST_TI-1].xr < 70'(gos_pkg::LN2_Q64), "range reduction left f >= ln2")
    `GOS_ASSERT_NOW(a_exp_le_one, vld_reg[ST_E], pipe_reg[ST_E].e <= 49'(gos_pkg::ONE_Q48), "exp above one")
    `GOS_ASSERT_NOW(a_pow_floor, vld_reg[ST_FL], pipe_reg[ST_FL].p >= 128'(gos_pkg::ONE_Q48), "power below one after floor")

endmodule

@@ sim/tb_gaussian_overlap_screen.sv @@
`timescale 1ns / 100ps

module tb_gaussian_overlap_screen;

    localparam int PIPE_LAT = 2 * 12 + 204;
    localparam logic [47:0] MAX48 = 48'hFFFFFFFFFFFF;

    class overlap_scoreboard;
        logic [47:0] pref;
        logic [47:0] decay;
        logic [3:0]  lval;
        logic [63:0] thresh;
        bit          sig_q[$];
        int          errors;

        function new();
            pref = '0;
            decay = '0;
            lval = '0;
            thresh = '0;
            errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [63:0] val);
            case (idx)
                gos_pkg::REG_PREFACTOR: pref = val[47:0];
                gos_pkg::REG_DECAY:     decay = val[47:0];
                gos_pkg::REG_TOTAL_L:   lval = val[3:0];
                default:                thresh = val;
            endcase
        endfunction

        function bit predict_sig(logic [191:0] coords);
            logic signed [32:0] diff;
            logic [31:0]  mag;
            logic [64:0]  acc;
            logic [63:0]  r2;
            logic [63:0]  root;
            logic [63:0]  cand;
            logic [127:0] pw;
            logic [191:0] wide;
            logic [127:0] xprod;
            logic [127:0] kq;
            logic [127:0] rem;
            logic [61:0]  frac;
            logic [63:0]  term;
            logic [63:0]  sum;
            logic [127:0] tp;
            logic [63:0]  ex;
            logic [127:0] scaled;
            int           lim;
            acc = '0;
            for (int i = 0; i < 3; i++)
            begin
                diff = $signed(coords[32*i +: 32]) - $signed(coords[32*(i+3) +: 32]);
                mag = diff < 0 ? 32'(-diff) : 32'(diff);
                acc = acc + 64'(mag) * 64'(mag);
                if (acc[64])
                    acc = {1'b0, 64'hFFFFFFFFFFFFFFFF};
            end
            r2 = acc[63:0];
            root = '0;
            for (int b = 63; b >= 0; b--)
            begin
                cand = root | (64'd1 << b);
                if (128'(cand) * 128'(cand) <= {r2, 64'd0})
                    root = cand;
            end
            lim = lval > 12 ? 12 : lval;
            pw = 128'(gos_pkg::ONE_Q48);
            for (int i = 0; i < lim; i++)
            begin
                wide = 192'(pw) * 192'(root);
                if (wide[191:176] != 0)
                    pw = '1;
                else
                    pw = wide[175:48];
            end
            if (pw < 128'(gos_pkg::ONE_Q48))
                pw = 128'(gos_pkg::ONE_Q48);
            xprod = 128'(decay) * 128'(r2);
            ex = '0;
            if (xprod[127:64] < 64)
            begin
                kq = xprod / 128'(gos_pkg::LN2_Q64);
                rem = xprod % 128'(gos_pkg::LN2_Q64);
                if (kq < 64)
                begin
                    frac = rem[63:2];
                    term = gos_pkg::ONE_Q62;
                    sum = gos_pkg::ONE_Q62;
                    for (int n = 1; n <= gos_pkg::EXP_TERMS; n++)
                    begin
                        tp = 128'(term) * 128'(frac);
                        term = tp[125:62] / 64'(n);
                        if (n % 2 == 1)
                            sum = sum - term;
                        else
                            sum = sum + term;
                    end
                    ex = (sum >> 14) >> kq[5:0];
                end
            end
            wide = 192'(pw) * 192'(ex);
            scaled = wide[175:48];
            wide = 192'(scaled) * 192'(pref);
            if (wide[191:88] != 0)
                return 1'b1;
            return wide[87:24] >= thresh;
        endfunction

        function void note_pair(logic [191:0] coords);
            sig_q.push_back(predict_sig(coords));
        endfunction

        function void check_result(logic [7:0] data);
            bit want;
            if (sig_q.size() == 0)
            begin
                $error("unexpected result beat, significant=%0d", data[0]);
                errors++;
                return;
            end
            want = sig_q.pop_front();
            if (data[0] !== want)
            begin
                $error("significant mismatch: expected %0d actual %0d", want, data[0]);
                errors++;
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [191:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [7:0]   m_axis_tdata;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [4:0]   paddr;
    logic [63:0]  pwdata;
    logic [63:0]  prdata;
    logic         pready;

    overlap_scoreboard sb;
    int in_idle;
    int out_idle;

    gaussian_overlap_screen dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= out_idle);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    task automatic write_reg(logic [1:0] idx, logic [63:0] val);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 5'(idx) * 5'd8;
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic load_setting(logic [47:0] pf, logic [47:0] dc, logic [3:0] l,
                                logic [63:0] ct);
        s_axis_tvalid <= 1'b0;
        while (sb.sig_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        write_reg(gos_pkg::REG_PREFACTOR, 64'(pf));
        write_reg(gos_pkg::REG_DECAY, 64'(dc));
        write_reg(gos_pkg::REG_TOTAL_L, 64'(l));
        write_reg(gos_pkg::REG_CUTOFF, ct);
    endtask

    // The valid stays high across back-to-back beats; it drops only for a gap.
    task automatic send_pair(logic [191:0] coords);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= coords;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_pair(coords);
        while ($urandom_range(99) < in_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
    endtask

    function automatic logic [191:0] near_pair();
        logic [191:0] c;
        logic [31:0]  base;
        int           sh;
        sh = $urandom_range(22);
        for (int i = 0; i < 3; i++)
        begin
            base = $urandom;
            c[32*i +: 32] = base;
            c[32*(i+3) +: 32] = base + ($signed($urandom) >>> (31 - sh));
        end
        return c;
    endfunction

    task automatic random_setting();
        logic [47:0] pf;
        logic [47:0] dc;
        logic [63:0] ct;
        case ($urandom_range(3))
            0: pf = MAX48;
            1: pf = '0;
            default: pf = 48'({$urandom, $urandom} >> $urandom_range(40));
        endcase
        dc = $urandom_range(7) == 0 ? ($urandom_range(1) ? MAX48 : 48'd0)
                                   : 48'({$urandom, $urandom} >> (8 + $urandom_range(38)));
        case ($urandom_range(5))
            0: ct = '1;
            1: ct = '0;
            default: ct = {$urandom, $urandom} >> $urandom_range(63);
        endcase
        load_setting(pf, dc, 4'($urandom_range(15)), ct);
    endtask

    initial
    begin
        logic [191:0] c;
        sb = new();
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_idle = 6;
        out_idle = 47;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values: cutoff 0 makes every pair significant.
        send_pair('0);
        send_pair({6{32'h7FFFFFFF}});
        // Largest L with full prefactor and a distance that overflows the power.
        load_setting(MAX48, 48'd0, 4'd12, '1);
        send_pair({{3{32'h80000000}}, {3{32'h7FFFFFFF}}});
        send_pair({{3{32'h7FFFFFFF}}, {3{32'h80000000}}});
        send_pair({{3{32'h00010000}}, {3{32'h00000000}}});
        send_pair('0);
        // L above the limit, estimate far above the cutoff width.
        load_setting(MAX48, 48'd0, 4'd15, 64'h0000_0001_0000_0000);
        send_pair({{3{32'h00400000}}, {3{32'hFFC00000}}});
        send_pair({{3{32'h00000001}}, {3{32'h00000000}}});
        send_pair({32'h0, 32'h0, 32'h7FFFFFFF, 32'h0, 32'h0, 32'h80000000});
        // Strong decay drives exp to zero for the most distant pair.
        load_setting(MAX48, MAX48, 4'd0, 64'd1);
        send_pair({{3{32'h00100000}}, {3{32'h00000000}}});
        send_pair({{3{32'h00000100}}, {3{32'h00000000}}});
        send_pair('0);
        // Zero prefactor against the smallest nonzero cutoff, then a nonzero prefactor against a zero cutoff.
        load_setting(48'd0, 48'h000100000000, 4'd3, 64'd1);
        send_pair({{3{32'h00020000}}, {3{32'h00000000}}});
        load_setting(48'h000001000000, 48'h000100000000, 4'd1, 64'd0);
        send_pair({{3{32'h00020000}}, {3{32'h00000000}}});
        // Moderate decay near the threshold.
        load_setting(48'h000001000000, 48'h000080000000, 4'd2, 64'h0000_1000_0000_0000);
        for (int i = 0; i < 8; i++)
            send_pair({32'h0, 32'h0, 32'(i) << 15, 32'h0, 32'h0, 32'h0});

        for (int mode = 0; mode < 3; mode++)
        begin
            in_idle = mode == 0 ? 6 : (mode == 1 ? 47 : 0);
            out_idle = mode == 0 ? 47 : (mode == 1 ? 6 : 0);
            for (int ph = 0; ph < 6; ph++)
            begin
                random_setting();
                for (int i = 0; i < 60; i++)
                begin
                    if ($urandom_range(9) == 0)
                        c = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
                    else
                        c = near_pair();
                    send_pair(c);
                end
            end
        end
        s_axis_tvalid <= 1'b0;

        while (sb.sig_q.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 50) @(posedge clk);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #10ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+sv
sv/gos_pkg.sv
sv/gaussian_overlap_screen.sv
sim/tb_gaussian_overlap_screen.sv
